// ===== hdl/tch_pkg.sv =====
// Shared types, constants and helper functions of the tilt-compensated heading core.
`timescale 1ns / 1ps
package tch_pkg;

  localparam int DW = 36;
  localparam int AW = 21;
  localparam int TABLE_LEN = 24;

  localparam logic signed [AW-1:0] Q_HALF_PI = 21'sd102944;
  localparam logic signed [AW-1:0] Q_TWO_PI = 21'sd411775;
  localparam logic [47:0] DEG64_MUL = 48'd240315917;
  localparam logic [47:0] ROUND_HALF = 48'h0000_8000_0000;
  localparam logic [15:0] FULL_TURN = 16'd23040;
  localparam longint INVK_INF = 64'd652032874;
  localparam longint INVK_TAIL = 64'd434688583;

  typedef enum logic [1:0] {
    REG_OFF_X = 2'd0,
    REG_OFF_Y = 2'd1,
    REG_OFF_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 zero;
    logic signed [DW-1:0] s0;
    logic signed [DW-1:0] s1;
    logic signed [DW-1:0] s2;
    logic signed [DW-1:0] s3;
    logic signed [AW-1:0] a0;
  } tok_t;

  typedef logic [47:0] prod_t;
  typedef logic [14:0] head_t;

  function automatic logic signed [AW-1:0] atan_q16(input int idx);
    logic signed [AW-1:0] v;
    case (idx)
      0: v = 21'sd51472;
      1: v = 21'sd30385;
      2: v = 21'sd16055;
      3: v = 21'sd8150;
      4: v = 21'sd4091;
      5: v = 21'sd2047;
      6: v = 21'sd1024;
      7: v = 21'sd512;
      8: v = 21'sd256;
      9: v = 21'sd128;
      10: v = 21'sd64;
      11: v = 21'sd32;
      12: v = 21'sd16;
      13: v = 21'sd8;
      14: v = 21'sd4;
      15: v = 21'sd2;
      16: v = 21'sd1;
      default: v = 21'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [DW-1:0] scale17(input logic signed [16:0] v);
    return {{(DW-29){v[16]}}, v, 12'b0};
  endfunction

  function automatic logic signed [DW-1:0] gain_mul(input logic signed [DW-1:0] v,
                                                   input logic signed [31:0] k);
    logic signed [63:0] p;
    logic signed [63:0] q;
    p = signed'(v[31:0]) * k;
    q = p >>> 30;
    return q[DW-1:0];
  endfunction

endpackage

// ===== hdl/tch_ifaces.sv =====
// Stream interfaces of the sensor sample channel and the heading channel.
`timescale 1ns / 1ps
interface tch_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;
  modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                output ready);
endinterface

interface tch_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] heading;
  modport source (output valid, heading, input ready);
  modport sink (input valid, heading, output ready);
endinterface

// ===== hdl/tch_pre.sv =====
// Quadrant pre-rotation cell at the head of each CORDIC chain.
`timescale 1ns / 1ps
module tch_pre #(
  parameter bit VEC = 1'b1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tch_pkg::tok_t up_tok,
  input  logic          up_vld,
  output logic          up_rdy,
  output tch_pkg::tok_t dn_tok,
  output logic          dn_vld,
  input  logic          dn_rdy
);

  tch_pkg::tok_t tok_r, tok_nxt;
  logic          vld_r;

  assign up_rdy = !vld_r || dn_rdy;

  always_comb begin
    tok_nxt = up_tok;
    if (VEC) begin
      tok_nxt.z = '0;
      tok_nxt.zero = (up_tok.x == '0) && (up_tok.y == '0);
      if (up_tok.x < 0) begin
        if (up_tok.y >= 0) begin
          tok_nxt.x = up_tok.y;
          tok_nxt.y = -up_tok.x;
          tok_nxt.z = tch_pkg::Q_HALF_PI;
        end else begin
          tok_nxt.x = -up_tok.y;
          tok_nxt.y = up_tok.x;
          tok_nxt.z = -tch_pkg::Q_HALF_PI;
        end
      end
    end else begin
      tok_nxt.zero = 1'b0;
      if (up_tok.z > tch_pkg::Q_HALF_PI) begin
        tok_nxt.x = -up_tok.y;
        tok_nxt.y = up_tok.x;
        tok_nxt.z = up_tok.z - tch_pkg::Q_HALF_PI;
      end else if (up_tok.z < -tch_pkg::Q_HALF_PI) begin
        tok_nxt.x = up_tok.y;
        tok_nxt.y = -up_tok.x;
        tok_nxt.z = up_tok.z + tch_pkg::Q_HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_tok = tok_r;
  assign dn_vld = vld_r;

endmodule

// ===== hdl/tch_cell.sv =====
// One CORDIC micro-rotation cell, vectoring or rotation mode.
`timescale 1ns / 1ps
module tch_cell #(
  parameter bit VEC = 1'b1,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tch_pkg::tok_t up_tok,
  input  logic          up_vld,
  output logic          up_rdy,
  output tch_pkg::tok_t dn_tok,
  output logic          dn_vld,
  input  logic          dn_rdy
);

  localparam logic signed [tch_pkg::AW-1:0] ATAN = tch_pkg::atan_q16(IDX);

  tch_pkg::tok_t               tok_r, tok_nxt;
  logic                        vld_r;
  logic signed [tch_pkg::DW-1:0] dx, dy;
  logic                        dir;

  assign up_rdy = !vld_r || dn_rdy;
  assign dx = up_tok.y >>> IDX;
  assign dy = up_tok.x >>> IDX;
  assign dir = VEC ? (up_tok.y > 0) : (up_tok.z < 0);

  always_comb begin
    tok_nxt = up_tok;
    if (dir) begin
      tok_nxt.x = up_tok.x + dx;
      tok_nxt.y = up_tok.y - dy;
      tok_nxt.z = VEC ? up_tok.z + ATAN : up_tok.z + ATAN;
    end else begin
      tok_nxt.x = up_tok.x - dx;
      tok_nxt.y = up_tok.y + dy;
      tok_nxt.z = up_tok.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_tok = tok_r;
  assign dn_vld = vld_r;

endmodule

// ===== hdl/tch_chain.sv =====
// A CORDIC chain: pre-rotation cell followed by a row of micro-rotation cells.
`timescale 1ns / 1ps
module tch_chain #(
  parameter bit VEC = 1'b1,
  parameter int NS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tch_pkg::tok_t up_tok,
  input  logic          up_vld,
  output logic          up_rdy,
  output tch_pkg::tok_t dn_tok,
  output logic          dn_vld,
  input  logic          dn_rdy
);

  tch_pkg::tok_t tk [NS+1];
  logic          vl [NS+1];
  logic          rd [NS+1];

  tch_pre #(.VEC(VEC)) u_pre (
    .clk(clk), .rst_n(rst_n),
    .up_tok(up_tok), .up_vld(up_vld), .up_rdy(up_rdy),
    .dn_tok(tk[0]), .dn_vld(vl[0]), .dn_rdy(rd[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_cell
    tch_cell #(.VEC(VEC), .IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .up_tok(tk[g]), .up_vld(vl[g]), .up_rdy(rd[g]),
      .dn_tok(tk[g+1]), .dn_vld(vl[g+1]), .dn_rdy(rd[g+1])
    );
  end

  assign rd[NS] = dn_rdy;
  assign dn_tok = tk[NS];
  assign dn_vld = vl[NS];

endmodule

// ===== hdl/tch_stage.sv =====
// Registered pipeline stage with valid/ready flow control for any payload type.
`timescale 1ns / 1ps
module tch_stage #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  T     up_data,
  input  logic up_vld,
  output logic up_rdy,
  output T     dn_data,
  output logic dn_vld,
  input  logic dn_rdy
);

  T     data_r;
  logic vld_r;

  assign up_rdy = !vld_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      data_r <= up_data;
    end
  end

  assign dn_data = data_r;
  assign dn_vld = vld_r;

endmodule

// ===== hdl/tilt_compensated_heading_core.sv =====
// Top level of the tilt-compensated compass heading core.
//
//   channel   direction  payload
//   in_ch     sink       accel_x/y/z, mag_x/y/z, signed 16 bit
//   out_ch    source     heading, unsigned 15 bit, 1/64 degree
//   cfg_*     write      cfg_index 2 bit, cfg_wdata 16 bit offsets
//
// One sample is taken per cycle while in_ch.ready is high; the pipeline depth grows
// with N, the clamped stage count, through the five CORDIC chains.
// Every stage has its own valid bit, so bubbles close up under a stall and
// in_ch.ready falls only when the whole row is full. Reset clears all valid
// bits and the offset registers.
`timescale 1ns / 1ps
module tilt_compensated_heading_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tch_in_if.sink      in_ch,
  tch_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int NS = (CORDIC_STAGES > tch_pkg::TABLE_LEN) ? tch_pkg::TABLE_LEN
                                                           : CORDIC_STAGES;
  localparam longint IK64 = tch_pkg::INVK_INF + (tch_pkg::INVK_TAIL >> (2 * NS));
  localparam logic signed [31:0] IK = 32'(IK64);

  logic signed [15:0] off_x_r, off_y_r, off_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tch_pkg::REG_OFF_X: off_x_r <= cfg_wdata;
        tch_pkg::REG_OFF_Y: off_y_r <= cfg_wdata;
        tch_pkg::REG_OFF_Z: off_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tch_pkg::tok_t t0, t1, g1_in, g1, c3_in, t3, g3_in, g3, c5_in, t4, c2_in, t2, t5;
  logic v1, r1, vg1, rg1, v2, r2, v3, r3, vg3, rg3, v4, r4, v5, r5, vp, rp;
  logic signed [tch_pkg::AW-1:0] pitch, ang, ang_w;
  tch_pkg::prod_t prod_in, prod, sum;
  logic [15:0] h16;
  tch_pkg::head_t head_in;

  always_comb begin
    t0 = '0;
    t0.x = tch_pkg::scale17(17'(in_ch.accel_z));
    t0.y = tch_pkg::scale17(17'(in_ch.accel_y));
    t0.s0 = tch_pkg::scale17(17'(in_ch.accel_x));
    t0.s1 = tch_pkg::scale17(17'(in_ch.mag_x) - 17'(off_x_r));
    t0.s2 = tch_pkg::scale17(17'(in_ch.mag_y) - 17'(off_y_r));
    t0.s3 = tch_pkg::scale17(17'(in_ch.mag_z) - 17'(off_z_r));
  end

  tch_chain #(.VEC(1'b1), .NS(NS)) u_roll (
    .clk(clk), .rst_n(rst_n), .up_tok(t0), .up_vld(in_ch.valid), .up_rdy(in_ch.ready),
    .dn_tok(t1), .dn_vld(v1), .dn_rdy(r1)
  );

  always_comb begin
    g1_in = t1;
    g1_in.x = t1.zero ? '0 : tch_pkg::gain_mul(t1.x, IK);
    g1_in.y = -t1.s0;
    g1_in.z = '0;
    g1_in.zero = 1'b0;
    g1_in.a0 = t1.zero ? '0 : t1.z;
  end

  tch_stage #(.T(tch_pkg::tok_t)) u_g1 (
    .clk(clk), .rst_n(rst_n), .up_data(g1_in), .up_vld(v1), .up_rdy(r1),
    .dn_data(g1), .dn_vld(vg1), .dn_rdy(rg1)
  );

  assign c2_in = g1;

  tch_chain #(.VEC(1'b1), .NS(NS)) u_pitch (
    .clk(clk), .rst_n(rst_n), .up_tok(c2_in), .up_vld(vg1), .up_rdy(rg1),
    .dn_tok(t2), .dn_vld(v2), .dn_rdy(r2)
  );

  assign pitch = t2.zero ? '0 : t2.z;

  always_comb begin
    c3_in = t2;
    c3_in.x = t2.s1;
    c3_in.y = t2.s3;
    c3_in.z = -pitch;
  end

  tch_chain #(.VEC(1'b0), .NS(NS)) u_rot_p (
    .clk(clk), .rst_n(rst_n), .up_tok(c3_in), .up_vld(v2), .up_rdy(r2),
    .dn_tok(t3), .dn_vld(v3), .dn_rdy(r3)
  );

  always_comb begin
    g3_in = t3;
    g3_in.x = t3.s2;
    g3_in.y = tch_pkg::gain_mul(t3.y, IK);
    g3_in.z = t3.a0;
    g3_in.s0 = t3.x;
  end

  tch_stage #(.T(tch_pkg::tok_t)) u_g3 (
    .clk(clk), .rst_n(rst_n), .up_data(g3_in), .up_vld(v3), .up_rdy(r3),
    .dn_data(g3), .dn_vld(vg3), .dn_rdy(rg3)
  );

  tch_chain #(.VEC(1'b0), .NS(NS)) u_rot_r (
    .clk(clk), .rst_n(rst_n), .up_tok(g3), .up_vld(vg3), .up_rdy(rg3),
    .dn_tok(t4), .dn_vld(v4), .dn_rdy(r4)
  );

  always_comb begin
    c5_in = t4;
    c5_in.x = t4.s0;
    c5_in.y = t4.x;
  end

  tch_chain #(.VEC(1'b1), .NS(NS)) u_head (
    .clk(clk), .rst_n(rst_n), .up_tok(c5_in), .up_vld(v4), .up_rdy(r4),
    .dn_tok(t5), .dn_vld(v5), .dn_rdy(r5)
  );

  always_comb begin
    ang = t5.zero ? '0 : t5.z;
    ang_w = ang;
    if (ang_w < 0) begin
      ang_w = ang_w + tch_pkg::Q_TWO_PI;
    end
    if (ang_w >= tch_pkg::Q_TWO_PI) begin
      ang_w = ang_w - tch_pkg::Q_TWO_PI;
    end
    if (ang_w < 0) begin
      ang_w = '0;
    end
    prod_in = 48'(ang_w[18:0]) * tch_pkg::DEG64_MUL;
  end

  tch_stage #(.T(tch_pkg::prod_t)) u_conv (
    .clk(clk), .rst_n(rst_n), .up_data(prod_in), .up_vld(v5), .up_rdy(r5),
    .dn_data(prod), .dn_vld(vp), .dn_rdy(rp)
  );

  always_comb begin
    sum = prod + tch_pkg::ROUND_HALF;
    h16 = sum[47:32];
    if (h16 >= tch_pkg::FULL_TURN) begin
      h16 = h16 - tch_pkg::FULL_TURN;
    end
    head_in = h16[14:0];
  end

  tch_stage #(.T(tch_pkg::head_t)) u_out (
    .clk(clk), .rst_n(rst_n), .up_data(head_in), .up_vld(vp), .up_rdy(rp),
    .dn_data(out_ch.heading), .dn_vld(out_ch.valid), .dn_rdy(out_ch.ready)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.heading < 15'd23040))
    else $error("heading beyond full turn");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input blocked while output drains");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == tch_pkg::REG_OFF_X)) |=> (off_x_r == $past(cfg_wdata)))
    else $error("offset write lost");

endmodule
